@@ hdl/mtc_pkg.sv @@
// mtc_pkg: shared types, class codes and helpers for the morse timing classifier
// no dependencies; used by every file under hdl
package mtc_pkg;

    localparam int SYMBOL_SLOTS_DEF = 15;
    localparam int BASE_W           = 20;
    localparam int ELAPSED_W        = 24;
    localparam int TWICE_W          = ELAPSED_W + 1;
    localparam int CLASS_W          = 4;
    localparam int SYM_W            = 3;
    localparam int LEN_W            = 4;
    localparam int CODE_W           = 45;

    localparam logic [BASE_W-1:0] BASE_TIME_RESET = 20'd100000;

    localparam logic CMD_EVENT   = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    localparam logic [CLASS_W-1:0] CLS_SHORT_MARK  = 4'd0;
    localparam logic [CLASS_W-1:0] CLS_DIT         = 4'd1;
    localparam logic [CLASS_W-1:0] CLS_DIT_OR_DAH  = 4'd2;
    localparam logic [CLASS_W-1:0] CLS_DAH         = 4'd3;
    localparam logic [CLASS_W-1:0] CLS_LONG_MARK   = 4'd4;
    localparam logic [CLASS_W-1:0] CLS_SHORT_SPACE = 4'd5;
    localparam logic [CLASS_W-1:0] CLS_GOOD_SPACE  = 4'd6;
    localparam logic [CLASS_W-1:0] CLS_LONG_SPACE  = 4'd7;
    localparam logic [CLASS_W-1:0] CLS_CHAR_END    = 4'd8;
    localparam logic [CLASS_W-1:0] CLS_WORD_END    = 4'd9;

    localparam logic [SYM_W-1:0] SYM_LONG_SPACE = 3'd6;

    typedef struct packed {
        logic                 cmd;
        logic                 key_level;
        logic [ELAPSED_W-1:0] elapsed_us;
    } item_t;

    typedef struct packed {
        logic [CLASS_W-1:0] symbol_class;
        logic               code_done;
        logic [LEN_W-1:0]   code_length;
        logic [CODE_W-1:0]  code_symbols;
    } result_t;

    typedef struct packed {
        logic             append;
        logic             clear;
        logic [SYM_W-1:0] sym;
    } slot_ctl_t;

    function automatic logic [SYM_W-1:0] sym_code(input logic [CLASS_W-1:0] cls);
        logic [SYM_W-1:0] code;
        code = (cls == CLS_LONG_SPACE) ? SYM_LONG_SPACE : cls[SYM_W-1:0];
        return code;
    endfunction

endpackage

@@ hdl/mtc_classifier.sv @@
// mtc_classifier: sorts one period into a mark or space class
// depends on mtc_pkg
module mtc_classifier
(
    input  logic                           level,
    input  logic [mtc_pkg::TWICE_W-1:0]    twice,
    input  logic [mtc_pkg::BASE_W-1:0]     base,
    output logic [mtc_pkg::CLASS_W-1:0]    symbol_class
);

    logic [mtc_pkg::TWICE_W-1:0] t_half;
    logic [mtc_pkg::TWICE_W-1:0] t_three;
    logic [mtc_pkg::TWICE_W-1:0] t_four;
    logic [mtc_pkg::TWICE_W-1:0] t_top;
    logic [2:0]                  idx;

    always_comb
    begin
        t_half  = mtc_pkg::TWICE_W'(base);
        t_three = mtc_pkg::TWICE_W'(base) + (mtc_pkg::TWICE_W'(base) << 1);
        t_four  = mtc_pkg::TWICE_W'(base) << 2;
        // marks stop at 6 units, spaces at 4 units
        t_top   = level ? (t_three << 2) : (mtc_pkg::TWICE_W'(base) << 3);

        if (twice < t_half)
        begin
            idx = 3'd0;
        end
        else if (twice < t_three)
        begin
            idx = 3'd1;
        end
        else if (twice < t_four)
        begin
            idx = 3'd2;
        end
        else if (twice < t_top)
        begin
            idx = 3'd3;
        end
        else
        begin
            idx = 3'd4;
        end

        symbol_class = level ? mtc_pkg::CLASS_W'(idx)
                             : mtc_pkg::CLS_SHORT_SPACE + mtc_pkg::CLASS_W'(idx);
    end

endmodule

@@ hdl/mtc_slot_cell.sv @@
// mtc_slot_cell: one slot of the symbol buffer chain
// depends on mtc_pkg; fills when its left neighbor is filled and it is not
module mtc_slot_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mtc_pkg::slot_ctl_t            ctl,
    input  logic                          prev_filled,
    output logic                          filled,
    output logic [mtc_pkg::SYM_W-1:0]     sym
);

    logic                      filled_reg;
    logic                      filled_next;
    logic [mtc_pkg::SYM_W-1:0] sym_reg;
    logic [mtc_pkg::SYM_W-1:0] sym_next;

    always_comb
    begin
        filled_next = filled_reg;
        sym_next    = sym_reg;
        if (ctl.clear)
        begin
            filled_next = 1'b0;
            sym_next    = '0;
        end
        else if (ctl.append && prev_filled && !filled_reg)
        begin
            filled_next = 1'b1;
            sym_next    = ctl.sym;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
            sym_reg    <= '0;
        end
        else
        begin
            filled_reg <= filled_next;
            sym_reg    <= sym_next;
        end
    end

    assign filled = filled_reg;
    assign sym    = sym_reg;

endmodule

@@ hdl/morse_timing_classifier_core.sv @@
// morse_timing_classifier_core: top level of the morse key timing classifier
// depends on mtc_pkg, mtc_classifier, mtc_slot_cell
//
//  channel   signals                          direction  carries
//  item      item_valid/item_ready/item       in         key event or timeout tick
//  result    result_valid/result_ready/result out        one classified symbol
//  cfg       cfg_we/cfg_wdata                 in         base time in us
//
// one transaction per cycle while item_ready is high; a result shows in the cycle after its item is taken
// the result register lets the next item in while a result is being taken
// item_ready drops only while a result waits and result_ready is low
// reset clears the buffer chain, the level tracking and sets base time to 100000
module morse_timing_classifier_core
#(
    parameter int SYMBOL_SLOTS = mtc_pkg::SYMBOL_SLOTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  mtc_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output mtc_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [mtc_pkg::BASE_W-1:0]    cfg_wdata
);

    localparam int COUNT_W = $clog2(SYMBOL_SLOTS + 1);
    localparam int FLAT_W  = mtc_pkg::SYM_W * SYMBOL_SLOTS;

    logic [mtc_pkg::BASE_W-1:0]  base_reg;
    logic                        last_level_reg;
    logic                        level_seen_reg;
    logic                        timed_out_reg;
    logic [COUNT_W-1:0]          count_reg;
    logic [COUNT_W-1:0]          count_next;
    logic                        result_valid_reg;
    mtc_pkg::result_t            result_reg;
    mtc_pkg::result_t            result_next;

    logic                        accept;
    logic                        event_take;
    logic                        tick_take;
    logic                        fire;
    logic                        cls_level;
    logic [mtc_pkg::TWICE_W-1:0] twice;
    logic [mtc_pkg::CLASS_W-1:0] cls;
    logic                        is_end;
    logic                        store_it;
    mtc_pkg::slot_ctl_t          slot_ctl;
    logic [SYMBOL_SLOTS:0]       filled_chain;
    logic [FLAT_W-1:0]           sym_flat;
    logic [4:0]                  count_wide;

    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    assign event_take = (item.cmd == mtc_pkg::CMD_EVENT)
                        && (!level_seen_reg || (item.key_level != last_level_reg));
    assign tick_take  = (item.cmd == mtc_pkg::CMD_TIMEOUT) && level_seen_reg && !timed_out_reg;
    assign fire       = accept && ((event_take && !timed_out_reg) || tick_take);

    // timeout stands for the opposite level lasting four units
    assign cls_level = (item.cmd == mtc_pkg::CMD_TIMEOUT) ? !last_level_reg : item.key_level;
    assign twice     = (item.cmd == mtc_pkg::CMD_TIMEOUT)
                       ? (mtc_pkg::TWICE_W'(base_reg) << 3)
                       : {item.elapsed_us, 1'b0};

    mtc_classifier u_classifier
    (
        .level        (cls_level),
        .twice        (twice),
        .base         (base_reg),
        .symbol_class (cls)
    );

    assign is_end   = (cls == mtc_pkg::CLS_CHAR_END) || (cls == mtc_pkg::CLS_WORD_END);
    assign store_it = fire && !is_end && (cls != mtc_pkg::CLS_GOOD_SPACE)
                      && !filled_chain[SYMBOL_SLOTS];

    assign slot_ctl.append = store_it;
    assign slot_ctl.clear  = fire && is_end;
    assign slot_ctl.sym    = mtc_pkg::sym_code(cls);

    assign filled_chain[0] = 1'b1;

    for (genvar i = 0; i < SYMBOL_SLOTS; i++)
    begin : g_slot
        mtc_slot_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (slot_ctl),
            .prev_filled (filled_chain[i]),
            .filled      (filled_chain[i+1]),
            .sym         (sym_flat[i*mtc_pkg::SYM_W +: mtc_pkg::SYM_W])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (slot_ctl.clear)
        begin
            count_next = '0;
        end
        else if (store_it)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    assign count_wide = 5'(count_reg);

    always_comb
    begin
        result_next              = '0;
        result_next.symbol_class = cls;
        if (is_end)
        begin
            result_next.code_done    = 1'b1;
            result_next.code_length  = (count_wide > 5'd15) ? 4'd15 : count_wide[3:0];
            result_next.code_symbols = mtc_pkg::CODE_W'(sym_flat);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg         <= mtc_pkg::BASE_TIME_RESET;
            last_level_reg   <= 1'b0;
            level_seen_reg   <= 1'b0;
            timed_out_reg    <= 1'b0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (accept && event_take)
            begin
                level_seen_reg <= 1'b1;
                timed_out_reg  <= 1'b0;
                last_level_reg <= item.key_level;
            end
            else if (accept && tick_take)
            begin
                timed_out_reg <= 1'b1;
            end
            count_reg <= count_next;
            if (fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ hdl/mtc_checker.sv @@
// mtc_checker: port-level assertions for morse_timing_classifier_core
// depends on mtc_pkg; bound to the top level at the end of this file
module mtc_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_ready,
    input  logic                          result_valid,
    input  logic                          result_ready,
    input  mtc_pkg::result_t              result
);

    // a stalled result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // nothing pending means the block takes the next transaction
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("item_ready low with no result pending");

    a_done_matches_class: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.code_done ==
            ((result.symbol_class == mtc_pkg::CLS_CHAR_END)
             || (result.symbol_class == mtc_pkg::CLS_WORD_END))))
        else $error("code_done disagrees with symbol_class");

    a_empty_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.code_done |->
            (result.code_length == '0) && (result.code_symbols == '0))
        else $error("code fields set on a plain symbol");

    // a zero-length code carries no symbols
    a_code_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.code_done && (result.code_length == '0)
        |-> (result.code_symbols == '0))
        else $error("code symbols present with zero length");

endmodule

bind morse_timing_classifier_core mtc_checker u_mtc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

@@ bench/tb_morse_timing_classifier_core.sv @@
// tb_morse_timing_classifier_core: self-checking bench for the morse timing classifier
// depends on mtc_pkg and morse_timing_classifier_core; a built-in predictor of the symbol
// classes and the held code checks every result transaction under random stalls and gaps
module tb_morse_timing_classifier_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS         = mtc_pkg::SYMBOL_SLOTS_DEF;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 148;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       item_valid   = 1'b0;
    logic                       item_ready;
    mtc_pkg::item_t             item         = '0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    mtc_pkg::result_t           result;
    logic                       cfg_we       = 1'b0;
    logic [mtc_pkg::BASE_W-1:0] cfg_wdata    = '0;

    morse_timing_classifier_core #(.SYMBOL_SLOTS(SLOTS)) u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always #5 clk = ~clk;

    logic [mtc_pkg::BASE_W-1:0] dit_us;
    logic [mtc_pkg::SYM_W-1:0]  held_syms [SLOTS];
    int                         held_count;
    logic                       prev_level;
    logic                       level_known;
    logic                       in_timeout;
    mtc_pkg::result_t           expected_symbols [$];

    int mismatches      = 0;
    int transactions    = 0;
    int symbols_checked = 0;
    int codes_checked   = 0;
    int settings_used   = 1;
    bit idle_on         = 1'b1;
    int gap_pct         = 20;
    int stall_pct       = 20;

    task automatic classify_period(input logic lvl, input logic [63:0] span);
        logic [63:0]                 twice;
        logic [63:0]                 b;
        logic [mtc_pkg::CLASS_W-1:0] cls;
        mtc_pkg::result_t            r;
        twice = span << 1;
        b = 64'(dit_us);
        if (lvl)
        begin
            if (twice < b)           cls = mtc_pkg::CLS_SHORT_MARK;
            else if (twice < 3 * b)  cls = mtc_pkg::CLS_DIT;
            else if (twice < 4 * b)  cls = mtc_pkg::CLS_DIT_OR_DAH;
            else if (twice < 12 * b) cls = mtc_pkg::CLS_DAH;
            else                     cls = mtc_pkg::CLS_LONG_MARK;
        end
        else
        begin
            if (twice < b)           cls = mtc_pkg::CLS_SHORT_SPACE;
            else if (twice < 3 * b)  cls = mtc_pkg::CLS_GOOD_SPACE;
            else if (twice < 4 * b)  cls = mtc_pkg::CLS_LONG_SPACE;
            else if (twice < 8 * b)  cls = mtc_pkg::CLS_CHAR_END;
            else                     cls = mtc_pkg::CLS_WORD_END;
        end
        if (cls != mtc_pkg::CLS_GOOD_SPACE && cls < mtc_pkg::CLS_CHAR_END
            && held_count < SLOTS)
        begin
            held_syms[held_count] = (cls == mtc_pkg::CLS_LONG_SPACE)
                                    ? mtc_pkg::SYM_LONG_SPACE : cls[mtc_pkg::SYM_W-1:0];
            held_count++;
        end
        r = '0;
        r.symbol_class = cls;
        if (cls >= mtc_pkg::CLS_CHAR_END)
        begin
            r.code_done   = 1'b1;
            r.code_length = mtc_pkg::LEN_W'(held_count);
            for (int i = 0; i < held_count; i++)
                r.code_symbols[mtc_pkg::SYM_W*i +: mtc_pkg::SYM_W] = held_syms[i];
            held_count = 0;
        end
        expected_symbols.push_back(r);
    endtask

    task automatic predict_symbol(input mtc_pkg::item_t it);
        if (it.cmd == mtc_pkg::CMD_EVENT)
        begin
            if (!level_known || it.key_level != prev_level)
            begin
                if (!in_timeout)
                    classify_period(it.key_level, 64'(it.elapsed_us));
                level_known = 1'b1;
                in_timeout  = 1'b0;
                prev_level  = it.key_level;
            end
        end
        else if (level_known && !in_timeout)
        begin
            // silence after activity reads as four units of the opposite level
            classify_period(~prev_level, 64'(dit_us) * 4);
            in_timeout = 1'b1;
        end
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        mtc_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_symbols.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected transaction, expected none, actual %p", $time, result);
            end
            else
            begin
                want = expected_symbols.pop_front();
                symbols_checked++;
                if (want.code_done)
                    codes_checked++;
                check_field("symbol_class", want.symbol_class, result.symbol_class);
                check_field("code_done", want.code_done, result.code_done);
                check_field("code_length", want.code_length, result.code_length);
                check_field("code_symbols", want.code_symbols, result.code_symbols);
            end
        end
    end

    initial
    begin
        @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 99) < stall_pct)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    task automatic send_item(input logic cmd, input logic lvl,
                             input logic [mtc_pkg::ELAPSED_W-1:0] us);
        mtc_pkg::item_t it;
        it = '{cmd: cmd, key_level: lvl, elapsed_us: us};
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predict_symbol(it);
        transactions++;
        if (idle_on && $urandom_range(0, 99) < gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (expected_symbols.size() != 0)
            @(posedge clk);
        // ignored items may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_dit_time(input logic [mtc_pkg::BASE_W-1:0] us);
        cfg_wdata <= us;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        dit_us = us;
        settings_used++;
    endtask

    function automatic logic [mtc_pkg::ELAPSED_W-1:0] pick_elapsed(input logic lvl);
        logic [63:0] b;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] elo;
        logic [63:0] ehi;
        int          pick;
        b = 64'(dit_us);
        pick = $urandom_range(0, 99);
        if (pick < 3)
            return mtc_pkg::ELAPSED_W'($urandom);
        if (lvl)
        begin
            if (pick < 8)       begin lo = 0;      hi = b;          end
            else if (pick < 53) begin lo = b;      hi = 3 * b;      end
            else if (pick < 63) begin lo = 3 * b;  hi = 4 * b;      end
            else if (pick < 95) begin lo = 4 * b;  hi = 12 * b;     end
            else                begin lo = 12 * b; hi = 64'd1 << 25; end
        end
        else
        begin
            if (pick < 10)      begin lo = 0;      hi = b;          end
            else if (pick < 60) begin lo = b;      hi = 3 * b;      end
            else if (pick < 70) begin lo = 3 * b;  hi = 4 * b;      end
            else if (pick < 90) begin lo = 4 * b;  hi = 8 * b;      end
            else                begin lo = 8 * b;  hi = 64'd1 << 25; end
        end
        elo = (lo + 1) >> 1;
        ehi = (hi == 0) ? 64'd0 : (hi - 1) >> 1;
        if (elo > ehi)
            return mtc_pkg::ELAPSED_W'(elo);
        case ($urandom_range(0, 4))
            0:       return mtc_pkg::ELAPSED_W'(elo);
            1:       return mtc_pkg::ELAPSED_W'(ehi);
            default: return mtc_pkg::ELAPSED_W'(elo + 64'($urandom) % (ehi - elo + 1));
        endcase
    endfunction

    task automatic test_timeout_ticks();
        send_item(mtc_pkg::CMD_TIMEOUT, 1'b0, '0);
        send_item(mtc_pkg::CMD_EVENT, 1'b1, 24'd200000);
        send_item(mtc_pkg::CMD_TIMEOUT, 1'b1, '1);
        send_item(mtc_pkg::CMD_TIMEOUT, 1'b0, '0);
        send_item(mtc_pkg::CMD_EVENT, 1'b1, 24'd50000);
        send_item(mtc_pkg::CMD_EVENT, 1'b0, 24'd50000);
        send_item(mtc_pkg::CMD_TIMEOUT, 1'b0, '0);
        send_item(mtc_pkg::CMD_EVENT, 1'b1, 24'd50000);
        drain_results();
    endtask

    task automatic test_dit_dah_bands();
        logic [mtc_pkg::ELAPSED_W-1:0] spaces [5];
        logic [mtc_pkg::ELAPSED_W-1:0] marks  [5];
        spaces = '{24'd49999, 24'd50000, 24'd150000, 24'd200000, 24'd400000};
        marks  = '{24'd0, 24'd50000, 24'd150000, 24'd200000, 24'hFFFFFF};
        for (int i = 0; i < 5; i++)
        begin
            send_item(mtc_pkg::CMD_EVENT, 1'b0, spaces[i]);
            send_item(mtc_pkg::CMD_EVENT, 1'b1, marks[i]);
        end
        drain_results();
    endtask

    task automatic test_buffer_overflow();
        set_dit_time(20'd1000);
        for (int i = 0; i < 8; i++)
        begin
            send_item(mtc_pkg::CMD_EVENT, 1'b0, 24'd0);
            send_item(mtc_pkg::CMD_EVENT, 1'b1, 24'd500);
        end
        send_item(mtc_pkg::CMD_EVENT, 1'b0, 24'd2000);
        drain_results();
    endtask

    task automatic test_zero_base();
        set_dit_time('0);
        send_item(mtc_pkg::CMD_EVENT, 1'b1, 24'd0);
        send_item(mtc_pkg::CMD_EVENT, 1'b0, 24'hFFFFFF);
        send_item(mtc_pkg::CMD_TIMEOUT, 1'b1, 24'd1);
        drain_results();
    endtask

    task automatic test_random_keying();
        logic [mtc_pkg::BASE_W-1:0] base;
        logic                       lvl;
        int                         roll;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       base = 20'd1000;
                1:       base = 20'd1000000;
                2:       base = 20'hFFFFF;
                3:       base = '0;
                4:       base = mtc_pkg::BASE_TIME_RESET;
                default: base = mtc_pkg::BASE_W'($urandom_range(1000, 1000000));
            endcase
            drain_results();
            set_dit_time(base);
            idle_on   = (p != PHASES - 1);
            gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    send_item(mtc_pkg::CMD_TIMEOUT, 1'($urandom),
                              mtc_pkg::ELAPSED_W'($urandom));
                else if (roll < 10)
                    send_item(mtc_pkg::CMD_EVENT, 1'($urandom),
                              mtc_pkg::ELAPSED_W'($urandom));
                else
                begin
                    lvl = level_known ? ~prev_level : 1'($urandom);
                    send_item(mtc_pkg::CMD_EVENT, lvl, pick_elapsed(lvl));
                end
                if (idle_on && $urandom_range(0, 59) == 0)
                    drain_results();
            end
        end
    endtask

    initial
    begin
        dit_us      = mtc_pkg::BASE_TIME_RESET;
        held_count  = 0;
        prev_level  = 1'b0;
        level_known = 1'b0;
        in_timeout  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_timeout_ticks();
        test_dit_dah_bands();
        test_buffer_overflow();
        test_zero_base();
        test_random_keying();
        drain_results();
        repeat (10) @(posedge clk);
        $display("covered %0d transactions across %0d dit time settings incl. zero and max",
                 transactions, settings_used);
        $display("checked %0d symbols, %0d of them code ends, %0d mismatches",
                 symbols_checked, codes_checked, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("watchdog expired with %0d symbols outstanding", expected_symbols.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
